// File: design/itrd_pkg.sv
// Shared types, constants and the digit character lookup for the radix digit converter.
package itrd_pkg;

    // Fixed field widths of the request and result channels
    localparam int NUMBER_W = 64;
    localparam int BASE_W   = 8;
    localparam int CHAR_W   = 7;
    localparam int DIGIT_W  = 6;

    // Parameter defaults
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int MAX_RADIX_DEF   = 36;

    // Radix rules
    localparam int MIN_RADIX     = 2;
    localparam int DEFAULT_RADIX = 10;
    localparam int DECIMAL_DIGITS = 10;
    localparam int ALPHABET_SIZE  = 36;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_Z    = 7'h7a;

    typedef struct packed {
        logic signed [NUMBER_W-1:0] number;
        logic [BASE_W-1:0]          base;
    } itrd_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              is_negative;
        logic              last_digit;
    } itrd_digit_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic read;
        logic advance;
    } itrd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic read_last;
    } itrd_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_SEND
    } itrd_state_t;

    // Map a digit value to lowercase ASCII; out-of-alphabet values clamp to 'z'
    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        if (dx < CHAR_W'(DECIMAL_DIGITS))
            return CHAR_ZERO + dx;
        else if (dx < CHAR_W'(ALPHABET_SIZE))
            return CHAR_A + dx - CHAR_W'(DECIMAL_DIGITS);
        else
            return CHAR_Z;
    endfunction

endpackage

// File: design/integer_to_radix_digits.sv
// Top level of the integer to radix digit converter with its assertions.
//
// Converts a signed VALUE_WIDTH-bit integer to lowercase ASCII digits in a radix of
// 2..MAX_RADIX (other radix values fall back to 10), emitting one digit per result,
// most significant first, with last_digit on the final one and is_negative on all of
// them; zero gives the single digit '0'. One request is handled at a time. All digits
// are first formed by the one-bit restoring divider, then each is emitted by a digit
// memory read followed by a send, which an output stall can hold. The digit memory
// needs no clearing after reset.
module integer_to_radix_digits #(
    parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_RADIX   = itrd_pkg::MAX_RADIX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  itrd_pkg::itrd_item_t  item,
    output logic                  digit_valid,
    input  logic                  digit_stall,
    output itrd_pkg::itrd_digit_t digit
);
    import itrd_pkg::*;

    itrd_cmd_t    cmd;
    itrd_status_t st;

    itrd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .st          (st),
        .cmd         (cmd)
    );

    itrd_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_RADIX   (MAX_RADIX)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cmd   (cmd),
        .st    (st),
        .digit (digit)
    );

    // No new request is taken while digits are being sent
    a_busy_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> item_stall)
        else $error("request accepted while digits pending");

    // A fresh request never shows a digit in the next cycle
    a_no_early_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> !digit_valid)
        else $error("digit shown right after request");

    // Delivering the last digit frees the block
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_valid && !digit_stall && digit.last_digit) |=> !item_stall)
        else $error("block not ready after last digit");

endmodule

// File: design/itrd_ctrl.sv
// Controller state machine: sequences load, bit-serial division and digit emission.
module itrd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    output logic                  digit_valid,
    input  logic                  digit_stall,
    input  itrd_pkg::itrd_status_t st,
    output itrd_pkg::itrd_cmd_t    cmd
);
    import itrd_pkg::*;

    itrd_state_t state_reg;
    itrd_state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Decide next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        item_stall  = 1'b1;
        digit_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (st.div_done)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                digit_valid = 1'b1;
                if (!digit_stall)
                begin
                    if (st.read_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// File: design/itrd_dp.sv
// Datapath: magnitude, one-bit-per-cycle restoring divider, digit memory and result fields.
module itrd_dp #(
    parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_RADIX   = itrd_pkg::MAX_RADIX_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  itrd_pkg::itrd_item_t   item,
    input  itrd_pkg::itrd_cmd_t    cmd,
    output itrd_pkg::itrd_status_t st,
    output itrd_pkg::itrd_digit_t  digit
);
    import itrd_pkg::*;

    localparam int RAD_W = $clog2(MAX_RADIX + 1);
    localparam int IDX_W = $clog2(VALUE_WIDTH);

    // Request capture
    logic [VALUE_WIDTH-1:0] value_in;
    logic                   neg_in;
    logic [VALUE_WIDTH-1:0] mag_in;
    logic [RAD_W-1:0]       radix_in;

    // Divider state
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [RAD_W-1:0]       rem_reg;
    logic [RAD_W-1:0]       radix_reg;
    logic                   neg_reg;
    logic [IDX_W-1:0]       bit_cnt_reg;
    logic [IDX_W-1:0]       wr_ptr_reg;
    logic [IDX_W-1:0]       rd_ptr_reg;

    // Divider step
    logic [RAD_W:0]         rem_shift;
    logic [RAD_W:0]         rem_sub;
    logic                   take;
    logic [RAD_W-1:0]       rem_step;
    logic [VALUE_WIDTH-1:0] quo_step;
    logic                   last_bit;

    // Digit memory
    logic [DIGIT_W-1:0] store_mem [VALUE_WIDTH];
    logic [DIGIT_W-1:0] rd_data_reg;

    // Form the magnitude and the effective radix
    always_comb
    begin
        value_in = item.number[VALUE_WIDTH-1:0];
        neg_in   = value_in[VALUE_WIDTH-1];
        mag_in   = neg_in ? (~value_in + VALUE_WIDTH'(1)) : value_in;
        if (item.base < BASE_W'(MIN_RADIX) || item.base > BASE_W'(MAX_RADIX))
            radix_in = RAD_W'(DEFAULT_RADIX);
        else
            radix_in = item.base[RAD_W-1:0];
    end

    // One restoring division step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        rem_sub   = rem_shift - {1'b0, radix_reg};
        take      = (rem_shift >= {1'b0, radix_reg});
        rem_step  = take ? rem_sub[RAD_W-1:0] : rem_shift[RAD_W-1:0];
        quo_step  = {quo_reg[VALUE_WIDTH-2:0], take};
        last_bit  = (bit_cnt_reg == IDX_W'(VALUE_WIDTH - 1));
    end

    assign st.div_done  = cmd.step && last_bit && (quo_step == '0);
    assign st.read_last = (rd_ptr_reg == '0);

    // Control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
        end
        else if (cmd.load)
        begin
            bit_cnt_reg <= '0;
            wr_ptr_reg  <= '0;
        end
        else if (cmd.step)
        begin
            if (last_bit)
            begin
                // Digit complete: restart the bit count, remember its slot, move on
                bit_cnt_reg <= '0;
                rd_ptr_reg  <= wr_ptr_reg;
                wr_ptr_reg  <= wr_ptr_reg + IDX_W'(1);
            end
            else
                bit_cnt_reg <= bit_cnt_reg + IDX_W'(1);
        end
        else if (cmd.advance)
            rd_ptr_reg <= rd_ptr_reg - IDX_W'(1);
    end

    // Dividend, remainder, radix and sign
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg   <= mag_in;
            rem_reg   <= '0;
            radix_reg <= radix_in;
            neg_reg   <= neg_in;
        end
        else if (cmd.step)
        begin
            quo_reg <= quo_step;
            // Restart the remainder for the next digit
            rem_reg <= last_bit ? '0 : rem_step;
        end
    end

    // Write each finished remainder; read digits most significant first
    always_ff @(posedge clk)
    begin
        if (cmd.step && last_bit)
            store_mem[wr_ptr_reg] <= DIGIT_W'(rem_step);
        if (cmd.read)
            rd_data_reg <= store_mem[rd_ptr_reg];
    end

    assign digit.digit_char  = digit_ascii(rd_data_reg);
    assign digit.is_negative = neg_reg;
    assign digit.last_digit  = st.read_last;

endmodule

// File: tb/sv/integer_to_radix_digits_tb.sv
// Self-checking testbench for the integer to radix digit converter.
module integer_to_radix_digits_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itrd_pkg::*;

    // Cycles with no request or digit accepted before the run is declared hung
    localparam int IDLE_LIMIT   = 20000;
    // Quiet cycles after the last digit to catch stray results
    localparam int TAIL_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 120;
    localparam int REPORT_MAX   = 10;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    itrd_item_t  item;
    logic        digit_valid;
    logic        digit_stall;
    itrd_digit_t digit;

    itrd_digit_t expected_digits[$];
    itrd_digit_t oldest_digit;

    int error_count;
    int requests_sent;
    int digits_checked;
    int fallback_requests;
    int negative_requests;
    int burst_left;
    int idle_cycles;

    stall_mode_t stall_mode;
    int          stall_mode_left;
    int          stall_phase;

    integer_to_radix_digits u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit       (digit)
    );

    // Free-running clock, 20 ns period
    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic void note_error(input string msg);
        if (error_count < REPORT_MAX)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endfunction

    // Convert one request to its digit sequence and queue it, most significant first
    function automatic void queue_expected_digits(input itrd_item_t req);
        logic [NUMBER_W-1:0] mag;
        logic [BASE_W-1:0]   radix;
        logic [DIGIT_W-1:0]  rems [64];
        logic                neg;
        itrd_digit_t         d;
        int                  n;
        neg   = req.number[NUMBER_W-1];
        mag   = req.number;
        if (neg)
            mag = ~mag + 64'd1;
        radix = req.base;
        if (radix < MIN_RADIX || radix > MAX_RADIX_DEF)
        begin
            radix = DEFAULT_RADIX;
            fallback_requests++;
        end
        if (neg)
            negative_requests++;
        n = 0;
        do
        begin
            rems[n] = DIGIT_W'(mag % radix);
            n++;
            mag = mag / radix;
        end
        while (mag != 0 && n < 64);
        for (int k = n - 1; k >= 0; k--)
        begin
            if (rems[k] < 10)
                d.digit_char = 7'h30 + CHAR_W'(rems[k]);
            else
                d.digit_char = 7'h61 + CHAR_W'(rems[k]) - 7'd10;
            d.is_negative = neg;
            d.last_digit  = (k == 0);
            expected_digits.push_back(d);
        end
    endfunction

    // Send one request; bursts of back-to-back requests alternate with random gaps
    task automatic send_request(input logic [NUMBER_W-1:0] number, input int base);
        itrd_item_t req;
        req.number = number;
        req.base   = BASE_W'(base);
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        item_valid <= 1'b1;
        item       <= req;
        do
            @(posedge clk);
        while (item_stall);
        queue_expected_digits(req);
        burst_left--;
        requests_sent++;
    endtask

    // Hold off new requests until every queued digit has come out
    task automatic wait_for_drain();
        item_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_digits.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [NUMBER_W-1:0] random_number();
        logic [NUMBER_W-1:0] v;
        int                  len;
        case ($urandom_range(0, 19))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7fff_ffff_ffff_ffff;
            2: v = '1;
            3: v = '0;
            default:
            begin
                len = $urandom_range(0, 64);
                v   = {$urandom, $urandom};
                if (len < 64)
                    v = v & ((64'd1 << len) - 64'd1);
                if ($urandom_range(0, 1))
                    v = ~v + 64'd1;
            end
        endcase
        return v;
    endfunction

    task automatic test_extremes();
        send_request(64'd0, 10);
        send_request(64'd0, 2);
        send_request(64'd1, 2);
        send_request(64'h7fff_ffff_ffff_ffff, 2);
        send_request(64'h8000_0000_0000_0000, 2);
        send_request(64'h8000_0000_0000_0000, 10);
        send_request(64'h8000_0000_0000_0000, 36);
        send_request(64'h7fff_ffff_ffff_ffff, 36);
        send_request('1, 16);
    endtask

    task automatic test_radix_fallback();
        send_request(64'd12345, 0);
        send_request(-64'sd987654321, 1);
        send_request(64'd36, 37);
        send_request(64'h7fff_ffff_ffff_ffff, 255);
    endtask

    task automatic test_alphabet();
        send_request(64'd35, 36);
        send_request(64'd36, 36);
        send_request(-64'sd35, 36);
        send_request(64'h0123_4567_89ab_cdef, 16);
        send_request(64'd34, 35);
        send_request(64'd1_000_000_007, 3);
        send_request(64'd2, 2);
    endtask

    // Random requests, mostly in-range radixes; pause once midway for a full drain
    task automatic test_random();
        int base;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                wait_for_drain();
            if ($urandom_range(0, 9) < 7)
                base = $urandom_range(MIN_RADIX, MAX_RADIX_DEF);
            else
                base = $urandom_range(0, 255);
            send_request(random_number(), base);
        end
    endtask

    // Check each accepted digit against the oldest queued expectation
    always @(posedge clk)
    begin
        if (rst_n && digit_valid && !digit_stall)
        begin
            if (expected_digits.size() == 0)
                note_error($sformatf("unexpected digit char=%h neg=%b last=%b",
                                     digit.digit_char, digit.is_negative, digit.last_digit));
            else
            begin
                oldest_digit = expected_digits.pop_front();
                digits_checked++;
                if (digit.digit_char !== oldest_digit.digit_char ||
                    digit.is_negative !== oldest_digit.is_negative ||
                    digit.last_digit !== oldest_digit.last_digit)
                    note_error($sformatf(
                        "digit mismatch: exp char=%h neg=%b last=%b, got char=%h neg=%b last=%b",
                        oldest_digit.digit_char, oldest_digit.is_negative,
                        oldest_digit.last_digit, digit.digit_char, digit.is_negative,
                        digit.last_digit));
            end
        end
    end

    // Drive the output stall from a randomly chosen mode that is redrawn when its countdown runs out
    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      <= stall_mode_t'($urandom_range(0, 3));
            stall_mode_left <= $urandom_range(50, 400);
        end
        else
            stall_mode_left <= stall_mode_left - 1;
        stall_phase <= (stall_phase == 4) ? 0 : stall_phase + 1;
        case (stall_mode)
            STALL_NONE:     digit_stall <= 1'b0;
            STALL_LIGHT:    digit_stall <= ($urandom_range(0, 99) < 25);
            STALL_HEAVY:    digit_stall <= ($urandom_range(0, 99) < 70);
            STALL_PERIODIC: digit_stall <= (stall_phase < 2);
            default:        digit_stall <= 1'b0;
        endcase
    end

    // End the run if nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (digit_valid && !digit_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles, %0d digits outstanding",
                     idle_cycles, expected_digits.size());
            $display("integer_to_radix_digits_tb: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n             = 1'b0;
        item_valid        = 1'b0;
        item              = '0;
        digit_stall       = 1'b0;
        stall_mode        = STALL_NONE;
        stall_mode_left   = 0;
        stall_phase       = 0;
        idle_cycles       = 0;
        error_count       = 0;
        requests_sent     = 0;
        digits_checked    = 0;
        fallback_requests = 0;
        negative_requests = 0;
        burst_left        = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_radix_fallback();
        test_alphabet();
        wait_for_drain();
        test_random();

        // Drain, then watch a quiet tail for stray digits
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d requests converted (%0d negative, %0d with fallback radix)",
                 requests_sent, negative_requests, fallback_requests);
        $display("%0d digits checked, %0d errors", digits_checked, error_count);
        if (error_count == 0 && expected_digits.size() == 0)
            $display("integer_to_radix_digits_tb: PASS");
        else
            $display("integer_to_radix_digits_tb: FAIL");
        $finish;
    end

endmodule
